@@ rtl/lcm_pkg.sv @@
`default_nettype none

package lcm_pkg;

    // Operand and result geometry
    localparam int OPERAND_WIDTH   = 27;
    localparam int PROD_WIDTH      = 2 * OPERAND_WIDTH;
    localparam int MULTIPLE_WIDTH  = 54;
    localparam int SHIFT_WIDTH     = $clog2(OPERAND_WIDTH);
    localparam int IN_TDATA_WIDTH  = ((2 * OPERAND_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_WIDTH = ((MULTIPLE_WIDTH + 7) / 8) * 8;

    // Microprogram geometry
    localparam int STEP_WIDTH = 4;

    localparam logic [STEP_WIDTH-1:0] STEP_IDLE     = 4'd0;
    localparam logic [STEP_WIDTH-1:0] STEP_CHECK    = 4'd1;
    localparam logic [STEP_WIDTH-1:0] STEP_TWOS     = 4'd2;
    localparam logic [STEP_WIDTH-1:0] STEP_X_ODD    = 4'd3;
    localparam logic [STEP_WIDTH-1:0] STEP_GCD      = 4'd4;
    localparam logic [STEP_WIDTH-1:0] STEP_SCALE    = 4'd5;
    localparam logic [STEP_WIDTH-1:0] STEP_DIV_INIT = 4'd6;
    localparam logic [STEP_WIDTH-1:0] STEP_DIV      = 4'd7;
    localparam logic [STEP_WIDTH-1:0] STEP_MUL_INIT = 4'd8;
    localparam logic [STEP_WIDTH-1:0] STEP_MUL      = 4'd9;
    localparam logic [STEP_WIDTH-1:0] STEP_OUT      = 4'd10;
    localparam logic [STEP_WIDTH-1:0] STEP_BACK     = 4'd11;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_HALVE_BOTH,
        OP_HALVE_X,
        OP_GCD_STEP,
        OP_SCALE_G,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_MUL_INIT,
        OP_MUL_STEP,
        OP_PRESENT
    } op_t;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_ERR,
        C_BOTH_EVEN,
        C_X_EVEN,
        C_Y_NONZERO,
        C_CNT_NONZERO,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t                   op;
        cond_t                 cond;
        logic [STEP_WIDTH-1:0] target;
    } ctrl_word_t;

    // Status flags from the datapath to the sequencer
    typedef struct packed {
        logic both_even;
        logic x_even;
        logic y_nonzero;
        logic cnt_nonzero;
        logic zero_error;
    } dp_status_t;

    // Control store: one word per step, jump taken when the condition holds
    function automatic ctrl_word_t rom_word(input logic [STEP_WIDTH-1:0] step);
        ctrl_word_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: STEP_IDLE};
        unique case (step)
            STEP_IDLE:     w = '{op: OP_LOAD,       cond: C_NO_INPUT,    target: STEP_IDLE};
            STEP_CHECK:    w = '{op: OP_NOP,        cond: C_ERR,         target: STEP_OUT};
            STEP_TWOS:     w = '{op: OP_HALVE_BOTH, cond: C_BOTH_EVEN,   target: STEP_TWOS};
            STEP_X_ODD:    w = '{op: OP_HALVE_X,    cond: C_X_EVEN,      target: STEP_X_ODD};
            STEP_GCD:      w = '{op: OP_GCD_STEP,   cond: C_Y_NONZERO,   target: STEP_GCD};
            STEP_SCALE:    w = '{op: OP_SCALE_G,    cond: C_NEVER,       target: STEP_IDLE};
            STEP_DIV_INIT: w = '{op: OP_DIV_INIT,   cond: C_NEVER,       target: STEP_IDLE};
            STEP_DIV:      w = '{op: OP_DIV_STEP,   cond: C_CNT_NONZERO, target: STEP_DIV};
            STEP_MUL_INIT: w = '{op: OP_MUL_INIT,   cond: C_NEVER,       target: STEP_IDLE};
            STEP_MUL:      w = '{op: OP_MUL_STEP,   cond: C_CNT_NONZERO, target: STEP_MUL};
            STEP_OUT:      w = '{op: OP_PRESENT,    cond: C_OUT_BUSY,    target: STEP_OUT};
            STEP_BACK:     w = '{op: OP_NOP,        cond: C_ALWAYS,      target: STEP_IDLE};
            default:       w = '{op: OP_NOP,        cond: C_ALWAYS,      target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ rtl/lcm_datapath.sv @@
`default_nettype none

module lcm_datapath (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire lcm_pkg::op_t                          op,
    input  wire logic [lcm_pkg::OPERAND_WIDTH-1:0]     first_operand,
    input  wire logic [lcm_pkg::OPERAND_WIDTH-1:0]     second_operand,
    output lcm_pkg::dp_status_t                        status,
    output logic      [lcm_pkg::MULTIPLE_WIDTH-1:0]    multiple
);

    localparam int OW = lcm_pkg::OPERAND_WIDTH;
    localparam int PW = lcm_pkg::PROD_WIDTH;
    localparam int SW = lcm_pkg::SHIFT_WIDTH;

    // Operands, GCD working pair, divider and multiplier registers
    logic [OW-1:0] a_reg, a_next;
    logic [OW-1:0] b_reg, b_next;
    logic [OW-1:0] x_reg, x_next;
    logic [OW-1:0] y_reg, y_next;
    logic [SW-1:0] k_reg, k_next;
    logic [OW-1:0] g_reg, g_next;
    logic [OW-1:0] rem_reg, rem_next;
    logic [OW-1:0] quot_reg, quot_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic          err_reg, err_next;

    logic [OW:0]   trial;
    logic [OW:0]   trial_diff;
    logic          x_gt_y;

    assign trial      = {rem_reg, quot_reg[OW-1]};
    assign trial_diff = trial - {1'b0, g_reg};
    assign x_gt_y     = x_reg > y_reg;

    // Status to the sequencer
    assign status.both_even   = !x_reg[0] && !y_reg[0];
    assign status.x_even      = !x_reg[0];
    assign status.y_nonzero   = y_reg != '0;
    assign status.cnt_nonzero = cnt_reg != '0;
    assign status.zero_error  = err_reg;

    assign multiple = err_reg ? '0 : lcm_pkg::MULTIPLE_WIDTH'(prod_reg);

    // Operation decode
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        k_next    = k_reg;
        g_next    = g_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        prod_next = prod_reg;
        cnt_next  = cnt_reg;
        err_next  = err_reg;
        unique case (op)
            lcm_pkg::OP_LOAD:
            begin
                a_next   = first_operand;
                b_next   = second_operand;
                x_next   = first_operand;
                y_next   = second_operand;
                k_next   = '0;
                err_next = (first_operand == '0) || (second_operand == '0);
            end
            lcm_pkg::OP_HALVE_BOTH:
            begin
                // strip common factors of two, counting them
                if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
            end
            lcm_pkg::OP_HALVE_X:
            begin
                if (!x_reg[0])
                    x_next = x_reg >> 1;
            end
            lcm_pkg::OP_GCD_STEP:
            begin
                // x stays odd; y is halved, or y takes the difference and x the smaller value
                if (y_reg != '0)
                begin
                    if (!y_reg[0])
                        y_next = y_reg >> 1;
                    else if (x_gt_y)
                    begin
                        x_next = y_reg;
                        y_next = x_reg - y_reg;
                    end
                    else
                        y_next = y_reg - x_reg;
                end
            end
            lcm_pkg::OP_SCALE_G:
                g_next = x_reg << k_reg;
            lcm_pkg::OP_DIV_INIT:
            begin
                rem_next  = '0;
                quot_next = a_reg;
                cnt_next  = SW'(OW - 1);
            end
            lcm_pkg::OP_DIV_STEP:
            begin
                // restoring division, one quotient bit per step
                if (!trial_diff[OW])
                begin
                    rem_next  = trial_diff[OW-1:0];
                    quot_next = {quot_reg[OW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = trial[OW-1:0];
                    quot_next = {quot_reg[OW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
            end
            lcm_pkg::OP_MUL_INIT:
            begin
                prod_next = '0;
                cnt_next  = SW'(OW - 1);
            end
            lcm_pkg::OP_MUL_STEP:
            begin
                // shift-add from the top bit of the quotient
                prod_next = {prod_reg[PW-2:0], 1'b0}
                          + (quot_reg[OW-1] ? PW'(b_reg) : PW'(0));
                quot_next = {quot_reg[OW-2:0], 1'b0};
                cnt_next  = cnt_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            err_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            err_reg <= err_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        k_reg    <= k_next;
        g_reg    <= g_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

@@ rtl/least_common_multiple.sv @@
// Least common multiple of two unsigned operands.
// Input channel s_*: one item per operand pair, accepted when s_tvalid and
// s_tready are both high. s_tready is high only while the sequencer sits at
// its idle step, so one item is in work at a time.
// Output channel m_*: one item per input item, m_tdata carries the LCM and
// m_tuser the zero-operand flag (the LCM then reads zero).
// Sequence: a microcoded sequencer steps a binary GCD loop (one halving or
// subtract per cycle), a 27-step restoring divide of the first operand by the
// GCD, and a 27-step shift-add multiply by the second operand. An item with a
// zero operand skips from the check step straight to the output step.
// After the result is loaded, the sequencer passes its back step and returns
// to idle, where the next item is accepted.
// Stall: the result sits in an output register; if it is still held when the
// next result is ready, the sequencer waits at its output step.
// Reset: rst_n clears the step counter and the output valid; the block then
// waits at idle with no item pending.
`default_nettype none

module least_common_multiple (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // first_operand [26:0], second_operand [53:27], zero fill above
    input  wire logic [lcm_pkg::IN_TDATA_WIDTH-1:0]     s_tdata,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // multiple [53:0], zero fill above
    output logic      [lcm_pkg::OUT_TDATA_WIDTH-1:0]    m_tdata,
    // zero_error [0]
    output logic                                        m_tuser
);

    localparam int OW = lcm_pkg::OPERAND_WIDTH;

    logic [lcm_pkg::STEP_WIDTH-1:0] step_reg, step_next;
    lcm_pkg::ctrl_word_t            word;
    lcm_pkg::op_t                   dp_op;
    lcm_pkg::dp_status_t            status;
    logic [lcm_pkg::MULTIPLE_WIDTH-1:0] multiple;
    logic                           out_busy;
    logic                           out_load;
    logic                           cond_true;

    logic                                 m_tvalid_reg, m_tvalid_next;
    logic [lcm_pkg::MULTIPLE_WIDTH-1:0]   mult_reg;
    logic                                 err_out_reg;

    assign word     = lcm_pkg::rom_word(step_reg);
    assign out_busy = m_tvalid_reg && !m_tready;
    assign out_load = (word.op == lcm_pkg::OP_PRESENT) && !out_busy;
    assign s_tready = step_reg == lcm_pkg::STEP_IDLE;

    // Jump condition select
    always_comb
    begin
        case (word.cond)
            lcm_pkg::C_NEVER:       cond_true = 1'b0;
            lcm_pkg::C_ALWAYS:      cond_true = 1'b1;
            lcm_pkg::C_NO_INPUT:    cond_true = !s_tvalid;
            lcm_pkg::C_ERR:         cond_true = status.zero_error;
            lcm_pkg::C_BOTH_EVEN:   cond_true = status.both_even;
            lcm_pkg::C_X_EVEN:      cond_true = status.x_even;
            lcm_pkg::C_Y_NONZERO:   cond_true = status.y_nonzero;
            lcm_pkg::C_CNT_NONZERO: cond_true = status.cnt_nonzero;
            lcm_pkg::C_OUT_BUSY:    cond_true = out_busy;
            default:                cond_true = 1'b0;
        endcase
    end

    // Step counter with conditional jump
    assign step_next = cond_true ? word.target : step_reg + 1'b1;

    // Gate operations that wait on a handshake
    always_comb
    begin
        dp_op = word.op;
        if ((word.op == lcm_pkg::OP_LOAD) && !s_tvalid)
            dp_op = lcm_pkg::OP_NOP;
        else if (word.op == lcm_pkg::OP_PRESENT)
            dp_op = lcm_pkg::OP_NOP;
    end

    lcm_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (dp_op),
        .first_operand  (s_tdata[OW-1:0]),
        .second_operand (s_tdata[2*OW-1:OW]),
        .status         (status),
        .multiple       (multiple)
    );

    // Output register valid
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= lcm_pkg::STEP_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            mult_reg    <= multiple;
            err_out_reg <= status.zero_error;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = lcm_pkg::OUT_TDATA_WIDTH'(mult_reg);
    assign m_tuser  = err_out_reg;

`ifndef SYNTHESIS
    // An accepted item moves the sequencer off the idle step
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sequencer stayed idle after accepting an item");

    // A flagged result carries a zero multiple
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("zero_error result with nonzero multiple");

    // The LCM of two nonzero operands is nonzero
    a_valid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata != '0)
        else $error("zero multiple without zero_error");

    // A result is never loaded over one still held by the receiver
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_busy |-> !out_load)
        else $error("output register overwritten while stalled");
`endif

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int OW          = lcm_pkg::OPERAND_WIDTH;
    localparam int MW          = lcm_pkg::MULTIPLE_WIDTH;
    localparam int DEC_MAX     = 99999999;
    localparam int RANDOM_PAIRS = 900;
    localparam int CALM_TAIL   = 120;
    localparam int LONG_HOLD   = 400;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int unsigned OPERAND_MAX = 32'hFFFF_FFFF >> (32 - OW);

    typedef struct {
        logic [OW-1:0] first;
        logic [OW-1:0] second;
        bit            drain_first;  // wait until all results are back
    } operand_pair_t;

    typedef struct {
        logic [MW-1:0] multiple;
        logic          zero_error;
    } lcm_result_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [lcm_pkg::IN_TDATA_WIDTH-1:0]  s_tdata = '0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [lcm_pkg::OUT_TDATA_WIDTH-1:0] m_tdata;
    logic                                m_tuser;

    operand_pair_t operand_queue[$];
    lcm_result_t   lcm_expected[$];
    int            failures = 0;
    int            items_accepted = 0;
    int            cycle_count = 0;
    int            send_gap = 0;
    int            hold_left = 0;
    bit            long_hold_done = 0;

    least_common_multiple DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // LCM via Euclid; zero operand flags an error with a zero multiple
    function automatic lcm_result_t predict_lcm(input logic [OW-1:0] a, input logic [OW-1:0] b);
        lcm_result_t r;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] rem;
        logic [63:0] prod;
        x = 64'(a);
        y = 64'(b);
        if (a == '0 || b == '0)
        begin
            r.multiple   = '0;
            r.zero_error = 1'b1;
        end
        else
        begin
            while (y != 0)
            begin
                rem = x % y;
                x   = y;
                y   = rem;
            end
            prod         = (64'(a) / x) * 64'(b);
            r.multiple   = prod[MW-1:0];
            r.zero_error = 1'b0;
        end
        return r;
    endfunction

    task automatic add_pair(input int unsigned a, input int unsigned b, input bit drain);
        operand_pair_t p;
        p.first       = OW'(a);
        p.second      = OW'(b);
        p.drain_first = drain;
        operand_queue.push_back(p);
    endtask

    // Random operand pairs, weighted toward shared factors and the decimal range
    function automatic operand_pair_t random_pair();
        operand_pair_t p;
        int unsigned g;
        int unsigned sh;
        p.drain_first = 0;
        case ($urandom_range(0, 9))
            0:
            begin
                p.first  = OW'($urandom);
                p.second = OW'($urandom);
            end
            1, 2, 3:
            begin
                p.first  = OW'($urandom_range(1, DEC_MAX));
                p.second = OW'($urandom_range(1, DEC_MAX));
            end
            4, 5:
            begin
                g        = $urandom_range(1, 1 << $urandom_range(1, 20));
                p.first  = OW'(g * $urandom_range(1, DEC_MAX / g));
                p.second = OW'(g * $urandom_range(1, DEC_MAX / g));
            end
            6:
            begin
                sh       = $urandom_range(0, 20);
                p.first  = OW'(($urandom_range(0, 31) * 2 + 1) << sh);
                p.second = OW'(($urandom_range(0, 31) * 2 + 1) << $urandom_range(0, 20));
            end
            7:
            begin
                p.first  = OW'($urandom);
                p.second = p.first;
            end
            8:
            begin
                p.first  = OW'($urandom);
                p.second = OW'($urandom);
                if ($urandom_range(0, 2) == 0)
                begin
                    p.first = '0;
                end
                if ($urandom_range(0, 2) != 1)
                begin
                    p.second = '0;
                end
            end
            default:
            begin
                p.first  = OW'($urandom_range(1, 64));
                p.second = OW'($urandom_range(1, 64));
            end
        endcase
        return p;
    endfunction

    // Input driver: holds tdata while stalled, random gaps between items
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                lcm_expected.push_back(predict_lcm(s_tdata[OW-1:0], s_tdata[2*OW-1:OW]));
                items_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (operand_queue.size() > 0 &&
                         !(operand_queue[0].drain_first && lcm_expected.size() > 0))
                begin
                    s_tdata  <= {{(lcm_pkg::IN_TDATA_WIDTH - 2*OW){1'b0}},
                                 operand_queue[0].second, operand_queue[0].first};
                    s_tvalid <= 1'b1;
                    void'(operand_queue.pop_front());
                    if (operand_queue.size() >= CALM_TAIL && $urandom_range(0, 5) == 0)
                    begin
                        send_gap = $urandom_range(1, 6);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output ready: short random stalls, one long hold-off to back up the block
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!long_hold_done && items_accepted >= 40)
        begin
            long_hold_done = 1;
            hold_left      = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end
        else if (operand_queue.size() >= CALM_TAIL && $urandom_range(0, 5) == 0)
        begin
            hold_left = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Result monitor: compare each item with the oldest expectation
    always @(posedge clk)
    begin
        lcm_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (lcm_expected.size() == 0)
            begin
                $error("unexpected result item: multiple %0d, zero_error %0b",
                       m_tdata[MW-1:0], m_tuser);
                failures++;
            end
            else
            begin
                want = lcm_expected.pop_front();
                if (m_tdata[MW-1:0] !== want.multiple)
                begin
                    $error("multiple mismatch: expected %0d, actual %0d",
                           want.multiple, m_tdata[MW-1:0]);
                    failures++;
                end
                if (m_tuser !== want.zero_error)
                begin
                    $error("zero_error mismatch: expected %0b, actual %0b",
                           want.zero_error, m_tuser);
                    failures++;
                end
            end
        end
    end

    // Reset
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Stimulus and end of run
    initial
    begin
        operand_pair_t p;
        // zero operands
        add_pair(0, 0, 1'b0);
        add_pair(0, 5, 1'b0);
        add_pair(7, 0, 1'b0);
        add_pair(0, OPERAND_MAX, 1'b0);
        // ones and field extremes, including values above the decimal range
        add_pair(1, 1, 1'b0);
        add_pair(1, OPERAND_MAX, 1'b0);
        add_pair(OPERAND_MAX, 1, 1'b0);
        add_pair(OPERAND_MAX, OPERAND_MAX, 1'b0);
        add_pair(OPERAND_MAX, OPERAND_MAX - 1, 1'b0);
        add_pair(32'h5555555, 32'h2AAAAAA, 1'b0);
        // decimal range top, equal primes and distinct large values
        add_pair(DEC_MAX, DEC_MAX - 1, 1'b0);
        add_pair(99999989, 99999989, 1'b0);
        add_pair(99999989, 99999971, 1'b0);
        add_pair(DEC_MAX, DEC_MAX, 1'b0);
        // powers of two and common factors
        add_pair(1 << (OW-1), 1 << (OW-2), 1'b0);
        add_pair(1 << (OW-1), 3, 1'b0);
        add_pair(6, 4, 1'b0);
        add_pair(12, 18, 1'b0);
        add_pair(13, 17, 1'b0);
        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            p = random_pair();
            p.drain_first = (i == 0 || i == RANDOM_PAIRS / 2);
            operand_queue.push_back(p);
        end

        while (operand_queue.size() > 0 || s_tvalid)
        begin
            @(posedge clk);
        end
        while (lcm_expected.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);
        if (lcm_expected.size() > 0)
        begin
            $error("%0d expected results never arrived", lcm_expected.size());
            failures++;
        end
        if (failures == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $error("timeout after %0d cycles", cycle_count);
        $display("Test completed with failures");
        $finish;
    end

endmodule
